// ----- hdl/bh_pkg.sv -----
// Shared types and constants of the bigram histogram.
package bh_pkg;

    localparam int BH_ALPHABET    = 37;
    localparam int BH_NUM_BINS    = BH_ALPHABET * BH_ALPHABET;
    localparam int BH_CLASS_W     = $clog2(BH_ALPHABET);
    localparam int BH_BIN_W       = 11;
    localparam int BH_ADDR_W      = $clog2(BH_NUM_BINS);
    localparam int BH_COUNT_OUT_W = 16;
    localparam int BH_COUNT_WIDTH = 16;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [7:0]          char_code;
        logic                string_start;
        logic [BH_BIN_W-1:0] bin_index;
    } t_bh_in;

    typedef struct packed {
        logic                      counted;
        logic [BH_BIN_W-1:0]       bin_out;
        logic [BH_COUNT_OUT_W-1:0] count;
    } t_bh_out;

    // Decoded form of one accepted item, handed from the decoder to the update logic.
    typedef struct packed {
        logic                  is_read;
        logic                  do_inc;
        logic                  rd_ok;
        logic [BH_BIN_W-1:0]   bin;
        logic [BH_CLASS_W-1:0] next_class;
    } t_bh_op;

endpackage

// ----- hdl/bh_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module bh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1369
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bh_decode.sv -----
// Character classification and bin address generation for one item.
module bh_decode (
    input  bh_pkg::t_bh_in                  i_item,
    input  logic [bh_pkg::BH_CLASS_W-1:0]   i_prev_class,
    input  logic                            i_have_prev,
    output bh_pkg::t_bh_op                  o_op
);
    import bh_pkg::*;

    logic                  right_ok;
    logic [BH_CLASS_W-1:0] right_class;
    logic [BH_BIN_W-1:0]   pair_bin;
    logic                  do_inc;

    // Space is class 0, upper- and lower-case letters take classes 1 to 26, and digits
    // take classes 27 to 36.
    always_comb begin
        right_ok    = 1'b1;
        right_class = '0;
        if (i_item.char_code == 8'd32) begin
            right_class = '0;
        end else if (i_item.char_code >= 8'd65 && i_item.char_code <= 8'd90) begin
            right_class = BH_CLASS_W'(i_item.char_code - 8'd64);
        end else if (i_item.char_code >= 8'd97 && i_item.char_code <= 8'd122) begin
            right_class = BH_CLASS_W'(i_item.char_code - 8'd96);
        end else if (i_item.char_code >= 8'd48 && i_item.char_code <= 8'd57) begin
            right_class = BH_CLASS_W'(i_item.char_code - 8'd21);
        end else begin
            right_ok = 1'b0;
        end
    end

    assign pair_bin = BH_BIN_W'(BH_BIN_W'(i_prev_class) * BH_BIN_W'(BH_ALPHABET))
                      + BH_BIN_W'(right_class);
    assign do_inc   = (i_item.req_type == REQ_CHAR) && i_have_prev
                      && !i_item.string_start && right_ok;

    always_comb begin
        o_op.is_read    = (i_item.req_type == REQ_READ);
        o_op.do_inc     = do_inc;
        o_op.rd_ok      = (i_item.req_type == REQ_READ)
                          && (i_item.bin_index < BH_BIN_W'(BH_NUM_BINS));
        o_op.next_class = right_ok ? right_class : '0;
        if (i_item.req_type == REQ_READ) begin
            o_op.bin = i_item.bin_index;
        end else if (do_inc) begin
            o_op.bin = pair_bin;
        end else begin
            o_op.bin = '0;
        end
    end

endmodule

// ----- hdl/bigram_histogram.sv -----
// Flow: an item's bin is read from RAM at acceptance; in the update state it is modified,
// written back and its result enters the output register once that register is free.
// No new item is accepted before the update state ends, so a stalled consumer holds the input.
// Reset: synchronous; afterwards a clearing pass writes zero to all 1369 bins, one per
// cycle, and no item is accepted before that pass ends.
// Top level of the character bigram histogram.
module bigram_histogram #(
    parameter int COUNT_WIDTH = bh_pkg::BH_COUNT_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bh_pkg::t_bh_in i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bh_pkg::t_bh_out o_out_data
);
    import bh_pkg::*;

    // One-hot sequencer: clearing sweep, waiting for a beat, updating the bin just read.
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_UPD   = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [BH_ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [BH_CLASS_W-1:0] r_prev_class, n_prev_class;
    logic                  r_have_prev, n_have_prev;
    t_bh_op                r_op, n_op;
    logic                  r_out_valid, n_out_valid;
    t_bh_out               r_out_data, n_out_data;

    t_bh_op                dec_op;
    logic                  in_accept;
    logic                  slot_free;
    logic                  upd_done;

    logic                   ram_we;
    logic [BH_ADDR_W-1:0]   ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [BH_ADDR_W-1:0]   ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH+BH_COUNT_OUT_W-1:0] ext_inc;
    logic [COUNT_WIDTH+BH_COUNT_OUT_W-1:0] ext_rd;

    bh_decode u_decode (
        .i_item      (i_in_data),
        .i_prev_class(r_prev_class),
        .i_have_prev (r_have_prev),
        .o_op        (dec_op)
    );

    // The histogram store; its read data is registered, so the bin read at acceptance
    // is available during the update cycle and holds there until the next acceptance.
    bh_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(BH_NUM_BINS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (in_accept),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Only one item is in flight, so a write back always lands before the next read.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign ram_raddr  = (dec_op.do_inc || dec_op.rd_ok) ? dec_op.bin[BH_ADDR_W-1:0] : '0;

    // The output register takes a new result when it is empty or its beat is leaving.
    assign slot_free = !r_out_valid || !i_out_stall;
    assign upd_done  = (r_state == ST_UPD) && slot_free;

    // Saturating increment; the reported count is the low bits, zero-extended if narrow.
    assign cnt_inc = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata
                                                         : ram_rdata + 1'b1;
    assign ext_inc = {{BH_COUNT_OUT_W{1'b0}}, cnt_inc};
    assign ext_rd  = {{BH_COUNT_OUT_W{1'b0}}, ram_rdata};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_op.bin[BH_ADDR_W-1:0];
        ram_wdata = cnt_inc;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (upd_done && r_op.do_inc) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_prev_class = r_prev_class;
        n_have_prev  = r_have_prev;
        n_op         = r_op;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == BH_ADDR_W'(BH_NUM_BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_op    = dec_op;
                    n_state = ST_UPD;
                    // A character beat always becomes the left side of the next pair.
                    if (!dec_op.is_read) begin
                        n_prev_class = dec_op.next_class;
                        n_have_prev  = 1'b1;
                    end
                end
            end
            ST_UPD: begin
                if (slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out_data.counted = r_op.do_inc;
                    n_out_data.bin_out = r_op.bin;
                    if (r_op.do_inc) begin
                        n_out_data.count = ext_inc[BH_COUNT_OUT_W-1:0];
                    end else if (r_op.rd_ok) begin
                        n_out_data.count = ext_rd[BH_COUNT_OUT_W-1:0];
                    end else begin
                        n_out_data.count = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_prev_class <= '0;
            r_have_prev  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_prev_class <= n_prev_class;
            r_have_prev  <= n_have_prev;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hdl/bh_checker.sv -----
// Port-level checks of the bigram histogram, bound to the top level.
module bh_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input bh_pkg::t_bh_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input bh_pkg::t_bh_out o_out_data
);
    import bh_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // Only one item is worked on at a time: an accepted beat closes the input.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while an item was in flight");

    // An incremented bin always lies inside the histogram.
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.counted
            |-> o_out_data.bin_out < BH_BIN_W'(BH_NUM_BINS))
        else $error("counted bin outside the histogram");

endmodule

bind bigram_histogram bh_checker u_bh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
